// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is applied.
`define PSN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication built on the clocked form.
`define PSN_ASSERT_IMPL(label, pre, post, msg) \
    `PSN_ASSERT(label, (pre) |-> (post), msg)

`endif

// File: design/psn_pkg.sv
// Package: types, constants and helpers for the unit-sphere normalizer.
`timescale 1ns / 1ps
package psn_pkg;

    localparam int MAX_POINTS      = 65536;
    localparam int COORD_FRAC_BITS = 16;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = 48;
    localparam int SEXT_W = SUM_W - 32;

    // Dividend width covers 2^(64+2F); root width covers its square root.
    localparam int DVD_W  = 65 + 2 * COORD_FRAC_BITS;
    localparam int RAD_W  = DVD_W + (DVD_W % 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int DIV_CW = $clog2(DVD_W + 1);
    localparam int SQ_CW  = $clog2(ROOT_W + 1);

    localparam int NSH    = COORD_FRAC_BITS + 2;
    localparam int PROD_W = 80;
    localparam int Q_W    = PROD_W - NSH;

    localparam logic [DVD_W-1:0] K_NUM = DVD_W'(1) << (64 + 2 * COORD_FRAC_BITS);
    localparam logic [63:0] SCALE_THR =
        (64'd1 << (2 * COORD_FRAC_BITS)) / 64'd1000000000000;
    localparam logic [47:0] ONE_Q16_32 = 48'h0001_0000_0000;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] CMD_SUM  = 2'd0;
    localparam logic [1:0] CMD_MAX  = 2'd1;
    localparam logic [1:0] CMD_NORM = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [1:0] KIND_CENTER = 2'd0;
    localparam logic [1:0] KIND_SCALE  = 2'd1;
    localparam logic [1:0] KIND_POINT  = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic               last_point;
    } in_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [47:0]        scale_out;
        logic               count_overflow;
    } out_t;

    function automatic logic [47:0] sat_scale(input logic [ROOT_W-1:0] r);
        logic [ROOT_W+47:0] w;
        begin
            w = (ROOT_W + 48)'(r);
            if (|(w >> 48))
                return '1;
            return w[47:0];
        end
    endfunction

endpackage

// File: design/psn_front.sv
// Front end: request intake, command screening and the request queue.
`timescale 1ns / 1ps
module psn_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         point_valid,
    output logic         point_stall,
    input  psn_pkg::in_t point,
    output logic         q_valid,
    output psn_pkg::in_t q_item,
    input  logic         q_pop
);
    import psn_pkg::*;

    in_t                mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               push;
    logic               pop;

    assign point_stall = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    // Drop unknown commands at the door.
    assign push    = point_valid && !point_stall && (point.command != CMD_NONE);
    assign pop     = q_pop && q_valid;
    assign q_valid = (count_reg != '0);
    assign q_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= point;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: design/psn_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module psn_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [psn_pkg::DVD_W-1:0] dividend,
    input  logic [63:0]               divisor,
    output logic                      busy,
    output logic                      done,
    output logic [psn_pkg::DVD_W-1:0] quotient
);
    import psn_pkg::*;

    logic [DVD_W-1:0]  quo_reg;
    logic [63:0]       rem_reg;
    logic [63:0]       den_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [64:0]       rem_sh;
    logic              fits;

    assign rem_sh   = {rem_reg, quo_reg[DVD_W-1]};
    assign fits     = (rem_sh >= {1'b0, den_reg});
    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? 64'(rem_sh - {1'b0, den_reg}) : rem_sh[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: design/psn_sqrt.sv
// Serial integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module psn_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [psn_pkg::RAD_W-1:0]  radicand,
    output logic                       done,
    output logic [psn_pkg::ROOT_W-1:0] root
);
    import psn_pkg::*;

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SQ_CW-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic              fits;

    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = (ROOT_W + 3)'({root_reg, 2'b01});
    assign fits   = (rem_sh >= trial);
    assign done   = done_reg;
    assign root   = root_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? (ROOT_W + 1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQ_CW'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SQ_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: design/psn_back.sv
// Back end: pass state, arithmetic sequencer and result register.
`timescale 1ns / 1ps
module psn_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  psn_pkg::in_t  q_item,
    output logic          q_pop,
    output logic          result_valid,
    input  logic          result_stall,
    output psn_pkg::out_t result
);
    import psn_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_EXEC = 8'b0000_0010,
        ST_MAXU = 8'b0000_0100,
        ST_NORM = 8'b0000_1000,
        ST_CDIV = 8'b0001_0000,
        ST_SDIV = 8'b0010_0000,
        ST_SQRT = 8'b0100_0000,
        ST_EMIT = 8'b1000_0000
    } state_t;

    state_t             state_reg;
    in_t                cur_reg;
    logic [SUM_W-1:0]   sum_reg [3];
    logic [CNT_W-1:0]   cnt_reg;
    logic signed [31:0] cen_reg [3];
    logic [63:0]        max_reg;
    logic [47:0]        scale_reg;
    logic               ovf_reg;
    logic [63:0]        sq_reg [3];
    logic [55:0]        pl_reg [3];
    logic [55:0]        ph_reg [3];
    logic [1:0]         axis_reg;
    logic               started_reg;
    out_t               pend_reg;
    out_t               res_reg;
    logic               res_valid_reg;

    logic signed [31:0] pv [3];
    logic               neg [3];
    logic [31:0]        mag [3];
    logic [31:0]        norm [3];
    logic [SUM_W-1:0]   smag [3];
    logic [65:0]        dsum;
    logic [63:0]        dist_sq;
    logic [63:0]        new_max;
    logic [31:0]        qlow;
    logic signed [31:0] cen_new;

    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic [63:0]        div_den;
    logic               div_busy;
    logic               div_done;
    logic [DVD_W-1:0]   div_quo;
    logic               sq_start;
    logic               sq_done;
    logic [ROOT_W-1:0]  sq_root;

    assign pv[0] = cur_reg.px;
    assign pv[1] = cur_reg.py;
    assign pv[2] = cur_reg.pz;

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        logic signed [32:0] diff;
        logic [PROD_W-1:0]  prod;
        logic [Q_W-1:0]     q;
        logic [31:0]        qc;

        assign diff   = {pv[g][31], pv[g]} - {cen_reg[g][31], cen_reg[g]};
        assign neg[g] = diff[32];
        assign mag[g] = neg[g] ? 32'(-diff) : diff[31:0];
        assign smag[g] = sum_reg[g][SUM_W-1] ? SUM_W'(-sum_reg[g]) : sum_reg[g];

        always_comb
        begin
            prod = (PROD_W'(ph_reg[g]) << 24) + PROD_W'(pl_reg[g]);
            q    = prod[PROD_W-1:NSH];
            if (neg[g])
            begin
                qc      = (q > Q_W'(64'h8000_0000)) ? 32'h8000_0000 : q[31:0];
                norm[g] = 32'(-qc);
            end
            else
            begin
                qc      = (q > Q_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
                norm[g] = qc;
            end
        end
    end

    always_comb
    begin
        dsum    = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
        dist_sq = (|dsum[65:64]) ? '1 : dsum[63:0];
        new_max = (dist_sq > max_reg) ? dist_sq : max_reg;
        qlow    = div_quo[31:0];
        cen_new = sum_reg[axis_reg][SUM_W-1] ? 32'(-qlow) : qlow;
    end

    // Take a request only once the divider has gone quiet.
    assign q_pop = (state_reg == ST_IDLE) && q_valid && !div_busy;

    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = DVD_W'(smag[axis_reg]);
        div_den   = 64'(cnt_reg);
        if (state_reg == ST_MAXU)
        begin
            div_start = cur_reg.last_point && (new_max > SCALE_THR);
            div_dvd   = K_NUM;
            div_den   = new_max;
        end
        else if (state_reg == ST_CDIV)
        begin
            div_start = !started_reg;
        end
    end

    assign sq_start = (state_reg == ST_SDIV) && div_done;

    psn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    psn_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (RAD_W'(div_quo)),
        .done     (sq_done),
        .root     (sq_root)
    );

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_item;
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= 64'(mag[i] * mag[i]);
            pl_reg[i] <= 56'(mag[i] * scale_reg[23:0]);
            ph_reg[i] <= 56'(mag[i] * scale_reg[47:24]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
                cen_reg[i] <= '0;
            end
            cnt_reg       <= '0;
            max_reg       <= '0;
            scale_reg     <= ONE_Q16_32;
            ovf_reg       <= 1'b0;
            axis_reg      <= '0;
            started_reg   <= 1'b0;
            pend_reg      <= '0;
            res_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && !result_stall && state_reg != ST_EMIT)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                        state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    case (cur_reg.command)
                        CMD_SUM:
                        begin
                            if (cnt_reg == CNT_W'(MAX_POINTS))
                                ovf_reg <= 1'b1;
                            else
                            begin
                                for (int i = 0; i < 3; i++)
                                    sum_reg[i] <= sum_reg[i] + {{SEXT_W{pv[i][31]}}, pv[i]};
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                            axis_reg    <= '0;
                            started_reg <= 1'b0;
                            state_reg   <= cur_reg.last_point ? ST_CDIV : ST_IDLE;
                        end
                        CMD_MAX:  state_reg <= ST_MAXU;
                        CMD_NORM: state_reg <= ST_NORM;
                        default:  state_reg <= ST_IDLE;
                    endcase
                end
                ST_MAXU:
                begin
                    if (!cur_reg.last_point)
                    begin
                        max_reg   <= new_max;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        max_reg <= '0;
                        if (new_max > SCALE_THR)
                            state_reg <= ST_SDIV;
                        else
                        begin
                            scale_reg <= ONE_Q16_32;
                            pend_reg  <= '{kind: KIND_SCALE, out_x: '0, out_y: '0,
                                           out_z: '0, scale_out: ONE_Q16_32,
                                           count_overflow: ovf_reg};
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_NORM:
                begin
                    pend_reg  <= '{kind: KIND_POINT, out_x: norm[0], out_y: norm[1],
                                   out_z: norm[2], scale_out: '0,
                                   count_overflow: ovf_reg};
                    state_reg <= ST_EMIT;
                end
                ST_CDIV:
                begin
                    if (!started_reg)
                        started_reg <= 1'b1;
                    else if (div_done)
                    begin
                        // Store this axis, then move on or finish the centroid.
                        cen_reg[axis_reg] <= cen_new;
                        started_reg       <= 1'b0;
                        if (axis_reg == 2'd2)
                        begin
                            for (int i = 0; i < 3; i++)
                                sum_reg[i] <= '0;
                            cnt_reg   <= '0;
                            pend_reg  <= '{kind: KIND_CENTER, out_x: cen_reg[0],
                                           out_y: cen_reg[1], out_z: cen_new,
                                           scale_out: '0, count_overflow: ovf_reg};
                            state_reg <= ST_EMIT;
                        end
                        else
                            axis_reg <= axis_reg + 1'b1;
                    end
                end
                ST_SDIV:
                begin
                    if (div_done)
                        state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (sq_done)
                    begin
                        scale_reg <= sat_scale(sq_root);
                        pend_reg  <= '{kind: KIND_SCALE, out_x: '0, out_y: '0,
                                       out_z: '0, scale_out: sat_scale(sq_root),
                                       count_overflow: ovf_reg};
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (!res_valid_reg || !result_stall)
                    begin
                        res_reg       <= pend_reg;
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// File: design/point_set_unit_sphere_normalizer.sv
// Top level of the point set unit-sphere normalizer.
// Requests enter a four-deep queue that keeps taking them while the back end
// works. In the back end a sum-pass point passes the idle and execute states,
// a max-distance point also the max-update state, and a transform point the
// normalize and emit states and the output register. The last point of a sum
// pass runs three divisions on the shared serial divider. The last point of a
// max-distance pass runs one division and one square root on the divider and
// the root unit, which produce one bit per cycle, unless the maximum is at or
// below SCALE_THR, which yields a unit scale. Unknown commands are dropped at
// the queue. Results wait in an output register.
`timescale 1ns / 1ps
module point_set_unit_sphere_normalizer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          point_valid,
    output logic          point_stall,
    input  psn_pkg::in_t  point,
    output logic          result_valid,
    input  logic          result_stall,
    output psn_pkg::out_t result
);
    import psn_pkg::*;

    logic q_valid;
    in_t  q_item;
    logic q_pop;

    psn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    psn_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: design/psn_checker.sv
// Port-level checker for the normalizer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module psn_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          point_valid,
    input logic          point_stall,
    input psn_pkg::in_t  point,
    input logic          result_valid,
    input logic          result_stall,
    input psn_pkg::out_t result
);
    import psn_pkg::*;

    `PSN_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")
    `PSN_ASSERT_IMPL(a_scale_shape, result_valid && result.kind == KIND_SCALE, result.out_x == 0 && result.out_y == 0 && result.out_z == 0 && result.scale_out != 0, "malformed scale result")
    `PSN_ASSERT_IMPL(a_noscale_zero, result_valid && result.kind != KIND_SCALE, result.scale_out == 0, "scale field set outside scale result")
    `PSN_ASSERT_IMPL(a_kind_known, result_valid, result.kind == KIND_CENTER || result.kind == KIND_SCALE || result.kind == KIND_POINT, "result without a command")

endmodule

bind point_set_unit_sphere_normalizer psn_checker u_psn_checker (.*);
